// ----- hw/rtl/smpq_pkg.sv -----
// Shared types and constants for the sorted max priority queue.
package smpq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int VALUE_W             = 32;
  localparam int COUNT_W             = 5;
  localparam int STATUS_W            = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_DEQUEUED = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_DEQUEUE = 1'b1
  } mode_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic                      ins;
    logic                      deq;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  // Handed from one cell to the next one down the row.
  typedef struct packed {
    logic                      gt;
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

endpackage

// ----- hw/rtl/smpq_req_if.sv -----
// Request channel: insert or dequeue operations.
interface smpq_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ----- hw/rtl/smpq_rsp_if.sv -----
// Response channel: outcome of each operation.
interface smpq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] max_value;
  logic        [1:0]  status;
  logic        [4:0]  entry_count;

  modport source (output valid, output max_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input max_value, input status, input entry_count,
                  output ready);
endinterface

// ----- hw/rtl/sorted_max_priority_queue_unit.sv -----
// Top level of the sorted max priority queue: cell row, fill count, response register.
//
//  channel | dir | fields                            | transfer when
//  --------+-----+-----------------------------------+----------------------
//  req     | in  | mode, value                       | req.valid & req.ready
//  rsp     | out | max_value, status, entry_count    | rsp.valid & rsp.ready
//
// Every cell compares and shifts at once and the response is registered, so
// one transfer per cycle is sustained while rsp.ready stays high; the response
// is valid in the cycle after the request transfer.
// Reset (synchronous, active high) clears the fill count and the response
// valid flag; cell contents are left as they are.
// A stalled response holds; req.ready stays high while the response register
// is empty or being taken in the same cycle.
module sorted_max_priority_queue_unit #(
  parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  smpq_req_if.sink   req,
  smpq_rsp_if.source rsp
);
  import smpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             take;
  logic             is_full;
  logic             is_empty;
  status_t          status_next;
  cell_ctrl_t       ctrl;
  cell_link_t       links [QUEUE_DEPTH];

  // Accept whenever the response slot frees up this cycle.
  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);

  always_comb begin
    ctrl.value  = req.value;
    ctrl.ins    = 1'b0;
    ctrl.deq    = 1'b0;
    count_next  = count;
    status_next = STATUS_INSERTED;
    if (req.mode == MODE_INSERT) begin
      if (is_full) begin
        status_next = STATUS_FULL;
      end else begin
        ctrl.ins    = take;
        count_next  = count + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        ctrl.deq    = take;
        count_next  = count - CNT_W'(1);
        status_next = STATUS_DEQUEUED;
      end
    end
  end

  // Row of cells, largest value at cell 0.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_link_t                prev_link;
    logic signed [VALUE_W-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_link = '{gt: 1'b0, value: '0};
    end else begin : g_body
      assign prev_link = links[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_inner
      assign next_value = links[i+1].value;
    end

    smpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CNT_W'(i) < count),
      .prev_link  (prev_link),
      .next_value (next_value),
      .link       (links[i])
    );
  end

  // Fill count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.max_value   <= (status_next == STATUS_DEQUEUED) ? links[0].value : '0;
      rsp.status      <= status_next;
      rsp.entry_count <= COUNT_W'(count_next);
    end
  end

  // Fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // Head pair stays in descending order.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (links[0].value >= links[1].value))
    else $error("cells 0 and 1 out of order");

  // A dequeue returns what sat in cell 0.
  a_deq_head: assert property (@(posedge clk) disable iff (rst)
    (take && req.mode == MODE_DEQUEUE && !is_empty)
      |=> (rsp.max_value == $past(links[0].value)))
    else $error("dequeued value differs from head cell");

  // An empty report always comes with a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_EMPTY) |-> (rsp.entry_count == '0))
    else $error("empty status with non-zero count");

  // An accepted insert into a non-full row grows the count by one.
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (take && req.mode == MODE_INSERT && !is_full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow fill count");

endmodule

// ----- hw/rtl/smpq_cell.sv -----
// One storage cell of the sorted row.
module smpq_cell (
  input  logic                           clk,
  input  smpq_pkg::cell_ctrl_t           ctrl,
  input  logic                           occupied,
  input  smpq_pkg::cell_link_t           prev_link,
  input  logic signed [smpq_pkg::VALUE_W-1:0] next_value,
  output smpq_pkg::cell_link_t           link
);
  import smpq_pkg::*;

  logic signed [VALUE_W-1:0] entry;
  logic                      gt;

  // New value goes behind all stored values that are greater or equal.
  assign gt         = !occupied || (ctrl.value > entry);
  assign link.gt    = gt;
  assign link.value = entry;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_link.gt) begin
        entry <= prev_link.value;
      end else if (gt) begin
        entry <= ctrl.value;
      end
    end else if (ctrl.deq) begin
      entry <= next_value;
    end
  end

endmodule
